// File: src/pfe_pkg.sv
package pfe_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_BITS  = 32;

    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W     = $clog2(STACK_DEPTH);
    localparam int ALU_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int OPERAND_W  = 31;
    localparam int ANSWER_W   = 32;
    localparam int STATUS_W   = 3;

    localparam logic KIND_OPERAND  = 1'b0;
    localparam logic KIND_OPERATOR = 1'b1;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LEFTOVER = 3'd4;

    typedef struct packed {
        logic                 kind;
        logic [OPERAND_W-1:0] value;
        logic [1:0]           op;
        logic                 last;
    } token_t;

    typedef struct packed {
        logic signed [ANSWER_W-1:0] answer;
        logic [STATUS_W-1:0]        status;
    } result_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_ctl_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

// File: src/pfe_ram.sv
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/pfe_alu.sv
module pfe_alu
    import pfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alu_ctl_t              ctl,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output alu_rsp_t              rsp,
    output logic [VALUE_BITS-1:0] result
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_ADD  = 3'd1;
    localparam logic [2:0] P_MUL  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_NEG  = 3'd4;

    logic [2:0]            phase_reg, phase_next;
    logic                  done_reg, done_next;
    logic                  dz_reg, dz_next;
    logic                  sub_reg, sub_next;
    logic                  neg_reg, neg_next;
    logic [ALU_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] x_reg, x_next;
    logic [VALUE_BITS-1:0] y_reg, y_next;

    logic [VALUE_BITS:0]   add_p, add_q;
    logic                  add_sub;
    logic [VALUE_BITS+1:0] add_q_ext, add_out;
    logic [VALUE_BITS-1:0] mag_a, mag_b;
    logic                  qbit;

    assign add_q_ext = {1'b0, add_q};
    assign add_out   = {1'b0, add_p} + (add_sub ? ~add_q_ext : add_q_ext)
                     + {{(VALUE_BITS+1){1'b0}}, add_sub};

    assign mag_a = a[VALUE_BITS-1] ? (~a + 1'b1) : a;
    assign mag_b = b[VALUE_BITS-1] ? (~b + 1'b1) : b;
    assign qbit  = ~add_out[VALUE_BITS+1];

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        dz_next    = dz_reg;
        sub_next   = sub_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        add_p      = {1'b0, acc_reg};
        add_q      = {1'b0, y_reg};
        add_sub    = 1'b0;

        unique case (phase_reg)
            P_IDLE:
            begin
                if (ctl.start)
                begin
                    dz_next  = 1'b0;
                    sub_next = (ctl.op == OP_SUB);
                    case (ctl.op) inside
                        OP_ADD, OP_SUB:
                        begin
                            acc_next   = a;
                            y_next     = b;
                            phase_next = P_ADD;
                        end
                        OP_MUL:
                        begin
                            acc_next   = '0;
                            x_next     = a;
                            y_next     = b;
                            cnt_next   = ALU_CNT_W'(VALUE_BITS);
                            phase_next = P_MUL;
                        end
                        default:
                        begin
                            if (b == '0)
                            begin
                                dz_next   = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                acc_next   = '0;
                                x_next     = mag_a;
                                y_next     = mag_b;
                                neg_next   = a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
                                cnt_next   = ALU_CNT_W'(VALUE_BITS);
                                phase_next = P_DIV;
                            end
                        end
                    endcase
                end
            end
            P_ADD:
            begin
                add_sub    = sub_reg;
                acc_next   = add_out[VALUE_BITS-1:0];
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            P_MUL:
            begin
                add_q = {1'b0, x_reg};
                if (y_reg[0])
                begin
                    acc_next = add_out[VALUE_BITS-1:0];
                end
                x_next   = {x_reg[VALUE_BITS-2:0], 1'b0};
                y_next   = {1'b0, y_reg[VALUE_BITS-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ALU_CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
            end
            P_DIV:
            begin
                add_p   = {acc_reg, x_reg[VALUE_BITS-1]};
                add_q   = {1'b0, y_reg};
                add_sub = 1'b1;
                if (qbit)
                begin
                    acc_next = add_out[VALUE_BITS-1:0];
                end
                else
                begin
                    acc_next = {acc_reg[VALUE_BITS-2:0], x_reg[VALUE_BITS-1]};
                end
                x_next   = {x_reg[VALUE_BITS-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ALU_CNT_W'(1))
                begin
                    if (neg_reg)
                    begin
                        phase_next = P_NEG;
                    end
                    else
                    begin
                        acc_next   = {x_reg[VALUE_BITS-2:0], qbit};
                        done_next  = 1'b1;
                        phase_next = P_IDLE;
                    end
                end
            end
            P_NEG:
            begin
                add_p      = '0;
                add_q      = {1'b0, x_reg};
                add_sub    = 1'b1;
                acc_next   = add_out[VALUE_BITS-1:0];
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            dz_reg    <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg <= sub_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = acc_reg;

endmodule

// File: src/postfix_expression_evaluator.sv
// Evaluates a postfix expression one token per transfer. The top of the stack lives in a
// register and the rest in a single-port-read RAM. An operand token is taken in the idle
// state; an operator passes through a read state that fetches the second value, then runs
// on a shared iterative unit with one adder: add and subtract take one adder pass,
// multiply and divide step one bit per cycle, and a negative quotient adds a negate step.
// The token marked last passes through an emit state that loads the result, which waits
// in an output register until taken; errors are sticky until that result.
module postfix_expression_evaluator
    import pfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    token_valid,
    output logic    token_stall,
    input  token_t  token,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [STATUS_W-1:0]   err_reg, err_next;
    logic [VALUE_BITS-1:0] top_reg, top_next;
    logic [1:0]            op_reg, op_next;
    logic                  last_reg, last_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic [CNT_W-1:0]              cnt_m1, cnt_m2;
    logic [VALUE_BITS+OPERAND_W-1:0] operand_wide;
    logic [VALUE_BITS+ANSWER_W-1:0]  answer_wide;
    logic [STATUS_W-1:0]           emit_status;

    logic                  ram_we;
    logic [VALUE_BITS-1:0] ram_rdata;
    alu_ctl_t              alu_ctl;
    alu_rsp_t              alu_rsp;
    logic [VALUE_BITS-1:0] alu_result;

    assign cnt_m1       = count_reg - CNT_W'(1);
    assign cnt_m2       = count_reg - CNT_W'(2);
    assign operand_wide = {{VALUE_BITS{1'b0}}, token.value};
    assign answer_wide  = {{ANSWER_W{1'b0}}, top_reg};

    pfe_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cnt_m1[ADDR_W-1:0]),
        .wr_data (top_reg),
        .rd_addr (cnt_m2[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    pfe_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .a      (ram_rdata),
        .b      (top_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_comb
    begin
        if (err_reg != ST_OK)
        begin
            emit_status = err_reg;
        end
        else if (count_reg == '0)
        begin
            emit_status = ST_TOO_FEW;
        end
        else if (count_reg != CNT_W'(1))
        begin
            emit_status = ST_LEFTOVER;
        end
        else
        begin
            emit_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        ram_we         = 1'b0;
        alu_ctl.start  = 1'b0;
        alu_ctl.op     = op_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (token_valid)
                begin
                    op_next    = token.op;
                    last_next  = token.last;
                    state_next = token.last ? S_EMIT : S_IDLE;
                    if (err_reg != ST_OK)
                    begin
                        err_next = err_reg;
                    end
                    else if (token.kind == KIND_OPERAND)
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            ram_we     = (count_reg != '0);
                            top_next   = operand_wide[VALUE_BITS-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg < CNT_W'(2))
                    begin
                        err_next = ST_TOO_FEW;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                alu_ctl.start = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.div_zero)
                    begin
                        err_next = ST_DIV_ZERO;
                    end
                    else
                    begin
                        top_next   = alu_result;
                        count_next = cnt_m1;
                    end
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.status = emit_status;
                    out_next.answer = (emit_status == ST_OK) ?
                                      $signed(answer_wide[ANSWER_W-1:0]) : '0;
                    out_valid_next  = 1'b1;
                    count_next      = '0;
                    err_next        = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        op_reg   <= op_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign token_stall  = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
